FILE: sv/nrpt_pkg.sv
`default_nettype none

package nrpt_pkg;

    localparam int MAX_PROFILES_DEF = 64;

    localparam int RANGE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int STATUS_W = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_STEP,
        ST_LK_PRIME,
        ST_LK_STEP,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: sv/nrpt_ram.sv
`default_nettype none

module nrpt_ram #(
    parameter int DEPTH = nrpt_pkg::MAX_PROFILES_DEF,
    parameter int AW    = $clog2(nrpt_pkg::MAX_PROFILES_DEF),
    parameter int DW    = nrpt_pkg::RANGE_W
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/nearest_range_profile_table.sv
// Insert: the new range is written straight to the table when it is empty; otherwise
//   each stored range greater than the new one is first moved up one place.
// Lookup: answered without a table read on an empty table, a single entry or a hit
//   in the interval cache; otherwise the table is walked, one table read per midpoint.
// One item at a time; the next item is taken once the result is in the output register.
// Reset clears the count, the cache and the handshake; table contents stay undefined.
`default_nettype none

module nearest_range_profile_table #(
    parameter int MAX_PROFILES = nrpt_pkg::MAX_PROFILES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [nrpt_pkg::RANGE_W-1:0]  s_range_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [nrpt_pkg::INDEX_W-1:0]  m_profile_index,
    output logic      [nrpt_pkg::STATUS_W-1:0] m_status,
    output logic      [nrpt_pkg::COUNT_W-1:0]  m_entry_count
);

    localparam int AW = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;
    localparam int CW = $clog2(MAX_PROFILES + 1);
    localparam int RW = nrpt_pkg::RANGE_W;
    localparam logic [RW:0] NO_UPPER_BOUND = {1'b1, {RW{1'b0}}};

    nrpt_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     ind_reg, ind_next;
    logic [RW-1:0]     val_reg, val_next;
    logic [RW-1:0]     prev_reg, prev_next;
    logic [RW-1:0]     low_reg, low_next;
    logic              cache_valid_reg, cache_valid_next;
    logic [AW-1:0]     cache_index_reg, cache_index_next;
    logic [RW-1:0]     cache_low_reg, cache_low_next;
    logic [RW:0]       cache_high_reg, cache_high_next;
    logic [AW-1:0]     res_index_reg, res_index_next;
    nrpt_pkg::status_t res_status_reg, res_status_next;
    logic              m_valid_reg, m_valid_next;
    logic [AW-1:0]     m_index_reg, m_index_next;
    nrpt_pkg::status_t m_status_reg, m_status_next;
    logic [CW-1:0]     m_count_reg, m_count_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [RW-1:0]     wr_data;
    logic [AW-1:0]     rd_addr;
    logic [RW-1:0]     rd_data;

    logic              accept;
    logic [RW:0]       pair_sum;
    logic [RW-1:0]     mid;
    logic [CW:0]       ind_plus2;
    logic              cache_hit;

    nrpt_ram #(
        .DEPTH (MAX_PROFILES),
        .AW    (AW),
        .DW    (RW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready   = (state_reg == nrpt_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign pair_sum  = {1'b0, prev_reg} + {1'b0, rd_data};
    assign mid       = pair_sum[RW:1];
    assign ind_plus2 = (CW+1)'(ind_reg) + (CW+1)'(2);
    assign cache_hit = cache_valid_reg && (s_range_value >= cache_low_reg)
                       && ({1'b0, s_range_value} < cache_high_reg);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        ind_next         = ind_reg;
        val_next         = val_reg;
        prev_next        = prev_reg;
        low_next         = low_reg;
        cache_valid_next = cache_valid_reg;
        cache_index_next = cache_index_reg;
        cache_low_next   = cache_low_reg;
        cache_high_next  = cache_high_reg;
        res_index_next   = res_index_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_index_next     = m_index_reg;
        m_status_next    = m_status_reg;
        m_count_next     = m_count_reg;
        wr_en            = 1'b0;
        wr_addr          = pos_reg;
        wr_data          = val_reg;
        rd_addr          = '0;

        unique case (state_reg)
            nrpt_pkg::ST_IDLE: begin
                if (accept) begin
                    val_next        = s_range_value;
                    res_index_next  = '0;
                    res_status_next = nrpt_pkg::STATUS_OK;
                    state_next      = nrpt_pkg::ST_EMIT;
                    if (s_kind == nrpt_pkg::KIND_INSERT) begin
                        cache_valid_next = 1'b0;
                        if (count_reg >= CW'(MAX_PROFILES)) begin
                            res_status_next = nrpt_pkg::STATUS_FULL;
                        end else if (count_reg == '0) begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = s_range_value;
                            count_next = count_reg + CW'(1);
                        end else begin
                            pos_next   = AW'(count_reg);
                            rd_addr    = AW'(count_reg - CW'(1));
                            state_next = nrpt_pkg::ST_INS_STEP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = nrpt_pkg::STATUS_EMPTY;
                        end else if (count_reg == CW'(1)) begin
                            res_index_next = '0;
                        end else if (cache_hit) begin
                            res_index_next = cache_index_reg;
                        end else begin
                            ind_next   = '0;
                            low_next   = '0;
                            rd_addr    = '0;
                            state_next = nrpt_pkg::ST_LK_PRIME;
                        end
                    end
                end
            end
            nrpt_pkg::ST_INS_STEP: begin
                wr_en = 1'b1;
                if (pos_reg != '0 && rd_data > val_reg) begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - AW'(1);
                    rd_addr  = pos_reg - AW'(2);
                end else begin
                    count_next = count_reg + CW'(1);
                    state_next = nrpt_pkg::ST_EMIT;
                end
            end
            nrpt_pkg::ST_LK_PRIME: begin
                prev_next  = rd_data;
                rd_addr    = AW'(1);
                state_next = nrpt_pkg::ST_LK_STEP;
            end
            nrpt_pkg::ST_LK_STEP: begin
                if (mid <= val_reg) begin
                    ind_next  = ind_reg + AW'(1);
                    low_next  = mid;
                    prev_next = rd_data;
                    rd_addr   = AW'(ind_plus2);
                    if (ind_plus2 >= (CW+1)'(count_reg)) begin
                        cache_valid_next = 1'b1;
                        cache_index_next = ind_reg + AW'(1);
                        cache_low_next   = mid;
                        cache_high_next  = NO_UPPER_BOUND;
                        res_index_next   = ind_reg + AW'(1);
                        state_next       = nrpt_pkg::ST_EMIT;
                    end
                end else begin
                    cache_valid_next = 1'b1;
                    cache_index_next = ind_reg;
                    cache_low_next   = low_reg;
                    cache_high_next  = {1'b0, mid};
                    res_index_next   = ind_reg;
                    state_next       = nrpt_pkg::ST_EMIT;
                end
            end
            nrpt_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_index_next  = res_index_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = count_reg;
                    state_next    = nrpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nrpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= nrpt_pkg::ST_IDLE;
            count_reg       <= '0;
            cache_valid_reg <= 1'b0;
            cache_index_reg <= '0;
            cache_low_reg   <= '0;
            cache_high_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            cache_valid_reg <= cache_valid_next;
            cache_index_reg <= cache_index_next;
            cache_low_reg   <= cache_low_next;
            cache_high_reg  <= cache_high_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        ind_reg        <= ind_next;
        val_reg        <= val_next;
        prev_reg       <= prev_next;
        low_reg        <= low_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        m_index_reg    <= m_index_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_profile_index = nrpt_pkg::INDEX_W'(m_index_reg);
    assign m_status        = m_status_reg;
    assign m_entry_count   = nrpt_pkg::COUNT_W'(m_count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PROFILES))
        else $error("stored count above table depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == nrpt_pkg::STATUS_FULL)
            |-> (m_count_reg == CW'(MAX_PROFILES)))
        else $error("full status with table not full");

    a_insert_drops_cache: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind == nrpt_pkg::KIND_INSERT) |=> !cache_valid_reg)
        else $error("interval cache survived an insert");

endmodule

`default_nettype wire
